/* src/aabb_collision_resolve_unit_defines.svh */
// Assertion macros shared by the collision resolve unit.
`ifndef AABB_COLLISION_RESOLVE_UNIT_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ACR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/acr_pkg.sv */
// Types, constants and helper functions of the collision resolve unit.
`timescale 1ns / 1ps
package acr_pkg;

   localparam int COORD_BITS = 24;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   // Two guard bits hold every edge sum and penetration depth exactly.
   localparam int EXT_BITS   = COORD_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SIZE_BITS-1:0]  size_type;
   typedef logic signed [EXT_BITS-1:0]   ext_type;

   typedef enum logic [2:0] {
      SIDE_BOTTOM = 3'd0,
      SIDE_TOP    = 3'd1,
      SIDE_RIGHT  = 3'd2,
      SIDE_LEFT   = 3'd3,
      SIDE_NONE   = 3'd4
   } side_type;

   typedef struct packed {
      coord_type a_left;
      coord_type a_top;
      size_type  a_width;
      size_type  a_height;
      coord_type b_left;
      coord_type b_top;
      size_type  b_width;
      size_type  b_height;
   } req_item_type;

   typedef struct packed {
      logic      overlap;
      side_type  side;
      coord_type fix_x;
      coord_type fix_y;
   } rsp_item_type;

   function automatic ext_type sext_coord(input coord_type c);
      return ext_type'(c);
   endfunction

   function automatic ext_type zext_size(input size_type s);
      return signed'({{(EXT_BITS - SIZE_BITS){1'b0}}, s});
   endfunction

   // Clamp a wide value to the signed coordinate range.
   function automatic coord_type sat_coord(input ext_type v);
      logic [EXT_BITS-COORD_BITS:0] upper;
      upper = v[EXT_BITS-1:COORD_BITS-1];
      if (!v[EXT_BITS-1] && (|upper)) begin
         return {1'b0, {(COORD_BITS - 1){1'b1}}};
      end else if (v[EXT_BITS-1] && !(&upper)) begin
         return {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else begin
         return v[COORD_BITS-1:0];
      end
   endfunction

endpackage

/* src/acr_req_if.sv */
// Valid/ready channel that carries one box pair per item.
`timescale 1ns / 1ps
interface acr_req_if
   import acr_pkg::*;
;
   logic      valid;
   logic      ready;
   coord_type a_left;
   coord_type a_top;
   size_type  a_width;
   size_type  a_height;
   coord_type b_left;
   coord_type b_top;
   size_type  b_width;
   size_type  b_height;

   modport source (
      output valid, a_left, a_top, a_width, a_height,
             b_left, b_top, b_width, b_height,
      input  ready
   );

   modport sink (
      input  valid, a_left, a_top, a_width, a_height,
             b_left, b_top, b_width, b_height,
      output ready
   );
endinterface

/* src/acr_rsp_if.sv */
// Valid/ready channel that carries one resolved collision per item.
`timescale 1ns / 1ps
interface acr_rsp_if
   import acr_pkg::*;
;
   logic      valid;
   logic      ready;
   logic      overlap;
   side_type  side;
   coord_type fix_x;
   coord_type fix_y;

   modport source (
      output valid, overlap, side, fix_x, fix_y,
      input  ready
   );

   modport sink (
      input  valid, overlap, side, fix_x, fix_y,
      output ready
   );
endinterface

/* src/acr_resolve.sv */
// Combinational overlap test, contact side choice and position correction.
`timescale 1ns / 1ps
module acr_resolve
   import acr_pkg::*;
(
   input  req_item_type item,
   output rsp_item_type result
);

   ext_type al, at, aw, ah, bl, bt, bw, bh;
   ext_type ar, ab, br, bb;
   ext_type pb, pt, pl, pr;
   ext_type fx, fy;
   logic    hit;
   side_type side;

   always_comb begin
      al = sext_coord(item.a_left);
      at = sext_coord(item.a_top);
      aw = zext_size(item.a_width);
      ah = zext_size(item.a_height);
      bl = sext_coord(item.b_left);
      bt = sext_coord(item.b_top);
      bw = zext_size(item.b_width);
      bh = zext_size(item.b_height);

      ar = al + aw;
      ab = at + ah;
      br = bl + bw;
      bb = bt + bh;

      // Interiors intersect only when both boxes have area and the spans cross.
      hit = (al < ar) && (bl < br) && (al < br) && (bl < ar)
         && (at < ab) && (bt < bb) && (at < bb) && (bt < ab);

      pb = bb - at;
      pt = ab - bt;
      pl = ar - bl;
      pr = br - al;

      side = SIDE_NONE;
      fx   = al;
      fy   = at;
      if (hit) begin
         if ((pt < pb) && (pt < pl) && (pt < pr)) begin
            side = SIDE_BOTTOM;
            fy   = bt - ah;
         end else if ((pb < pt) && (pb < pl) && (pb < pr)) begin
            side = SIDE_TOP;
            fy   = bb;
         end else if ((pl < pr) && (pl < pt) && (pl < pb)) begin
            side = SIDE_RIGHT;
            fx   = bl - aw;
         end else if ((pr < pl) && (pr < pt) && (pr < pb)) begin
            side = SIDE_LEFT;
            fx   = br;
         end
      end

      result.overlap = hit;
      result.side    = side;
      result.fix_x   = sat_coord(fx);
      result.fix_y   = sat_coord(fy);
   end

endmodule

/* src/aabb_collision_resolve_unit.sv */
// Top level of the axis-aligned box collision resolve unit.
`timescale 1ns / 1ps
// An item accepted into the input register is resolved and then loaded into
// the result register, from which it is offered on the result channel.
// Throughput: one item per cycle while results are taken; the input register
// and the result register form a two-stage pipeline, and the single resolve
// stage between them sets it. Reset: synchronous and active high; it empties
// both stages, and the block is ready for an item once reset is released.
`include "aabb_collision_resolve_unit_defines.svh"
module aabb_collision_resolve_unit
   import acr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   acr_req_if.sink   req_bus,
   acr_rsp_if.source rsp_bus
);

   // Stage one holds the accepted box pair; stage two holds the finished result.
   req_item_type req_item;
   req_item_type stage_ff;
   logic         stage_valid_ff;
   logic         stage_valid_in;
   rsp_item_type resolved;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         stage_advance;
   logic         rsp_advance;

   // The result register frees when it is empty or its item is being taken;
   // stage one then moves forward, so items enter one per cycle unless results stall.
   // No item is taken while reset is held, since ready is held low during reset.
   assign rsp_advance   = !rsp_valid_ff || rsp_bus.ready;
   assign stage_advance = !stage_valid_ff || rsp_advance;
   assign req_bus.ready = stage_advance && !reset;

   always_comb begin
      req_item.a_left   = req_bus.a_left;
      req_item.a_top    = req_bus.a_top;
      req_item.a_width  = req_bus.a_width;
      req_item.a_height = req_bus.a_height;
      req_item.b_left   = req_bus.b_left;
      req_item.b_top    = req_bus.b_top;
      req_item.b_width  = req_bus.b_width;
      req_item.b_height = req_bus.b_height;
   end

   always_comb begin
      stage_valid_in = stage_advance ? req_bus.valid : stage_valid_ff;
      rsp_valid_in   = rsp_advance ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers load only when their stage takes a new item.
   always_ff @(posedge clock) begin
      if (stage_advance && req_bus.valid) begin
         stage_ff <= req_item;
      end
      if (rsp_advance && stage_valid_ff) begin
         rsp_ff <= resolved;
      end
   end

   acr_resolve u_resolve (
      .item   (stage_ff),
      .result (resolved)
   );

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.overlap = rsp_ff.overlap;
   assign rsp_bus.side    = rsp_ff.side;
   assign rsp_bus.fix_x   = rsp_ff.fix_x;
   assign rsp_bus.fix_y   = rsp_ff.fix_y;

   // A contact side is only ever reported for boxes that overlap.
   `ACR_ASSERT_NOW(a_side_needs_overlap, clock, reset,
      rsp_valid_ff && (rsp_ff.side != SIDE_NONE), rsp_ff.overlap,
      "contact side reported without overlap")

   // A vertical push leaves the horizontal position untouched.
   `ACR_ASSERT_NOW(a_vertical_keeps_x, clock, reset,
      stage_valid_ff && ((resolved.side == SIDE_TOP) || (resolved.side == SIDE_BOTTOM)),
      resolved.fix_x == stage_ff.a_left, "vertical push changed x")

   // Without overlap the result carries the moving box's own corner.
   `ACR_ASSERT_NEXT(a_miss_keeps_pos, clock, reset,
      stage_valid_ff && rsp_advance && !resolved.overlap,
      (rsp_ff.fix_x == $past(stage_ff.a_left)) && (rsp_ff.fix_y == $past(stage_ff.a_top))
         && (rsp_ff.side == SIDE_NONE),
      "miss did not keep position")

   // With the result register empty the block must take a new item.
   `ACR_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_bus.ready,
      "input stalled with empty result register")

endmodule

/* sim/tb_aabb_collision_resolve_unit.sv */
// Self-checking testbench of the box collision resolve unit with random stalls on both channels.
`timescale 1ns / 1ps
module tb_aabb_collision_resolve_unit;
   import acr_pkg::*;

   // Number of random box pairs that follow the directed pairs.
   localparam int RANDOM_PAIRS = 1150;
   // Several times what a correct run needs, even with every item behind the
   // longest gap on both sides.
   localparam int CYCLE_LIMIT  = 400000;
   // The block holds an item only in its input and result registers, so the
   // quiet cycles at the end are enough to catch a stray result.
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
   localparam longint SIZE_MAX  = (longint'(1) << SIZE_BITS) - 1;

   logic clock;
   logic reset;

   acr_req_if req_bus ();
   acr_rsp_if rsp_bus ();

   aabb_collision_resolve_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Box pairs waiting to be offered, and the resolved collisions that the
   // block still owes, oldest first.
   req_item_type pending_pairs[$];
   rsp_item_type expected_resolves[$];

   // The pair currently offered on the request channel.
   req_item_type pair_on_bus;
   bit           pair_held;

   int send_gap;
   int sink_stall;
   // While this runs down, neither side inserts gaps, so the block also sees
   // long stretches at full rate.
   int calm_cycles;
   int fault_count;
   int cycle_count;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Clamp a wide value into the signed coordinate range.
   function automatic coord_type clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(v);
   endfunction

   // Work out the collision that the block must report for one box pair.
   // All edge sums and depths are carried in 64 bits, so nothing wraps.
   function automatic rsp_item_type resolve_pair(input req_item_type p);
      longint al, at, aw, ah, bl, bt, bw, bh;
      longint ar, ab, br, bb;
      longint pen_b_bottom, pen_b_top, pen_b_left, pen_b_right;
      longint fx, fy;
      bit hit;
      rsp_item_type r;
      al = longint'(p.a_left);
      at = longint'(p.a_top);
      aw = longint'(p.a_width);
      ah = longint'(p.a_height);
      bl = longint'(p.b_left);
      bt = longint'(p.b_top);
      bw = longint'(p.b_width);
      bh = longint'(p.b_height);
      ar = al + aw;
      ab = at + ah;
      br = bl + bw;
      bb = bt + bh;
      // Interiors must intersect on both axes; touching edges do not count.
      hit = ((al > bl ? al : bl) < (ar < br ? ar : br)) &&
            ((at > bt ? at : bt) < (ab < bb ? ab : bb));
      r.overlap = hit;
      r.side    = SIDE_NONE;
      fx = al;
      fy = at;
      if (hit) begin
         // How far A reaches past each edge of B.
         pen_b_bottom = bb - at;
         pen_b_top    = ab - bt;
         pen_b_left   = ar - bl;
         pen_b_right  = br - al;
         if (pen_b_top < pen_b_bottom && pen_b_top < pen_b_left &&
             pen_b_top < pen_b_right) begin
            r.side = SIDE_BOTTOM;
            fy = bt - ah;
         end else if (pen_b_bottom < pen_b_top && pen_b_bottom < pen_b_left &&
                      pen_b_bottom < pen_b_right) begin
            r.side = SIDE_TOP;
            fy = bb;
         end else if (pen_b_left < pen_b_right && pen_b_left < pen_b_top &&
                      pen_b_left < pen_b_bottom) begin
            r.side = SIDE_RIGHT;
            fx = bl - aw;
         end else if (pen_b_right < pen_b_left && pen_b_right < pen_b_top &&
                      pen_b_right < pen_b_bottom) begin
            r.side = SIDE_LEFT;
            fx = br;
         end
         // Any tie for the smallest depth leaves the side at none.
      end
      r.fix_x = clamp_coord(fx);
      r.fix_y = clamp_coord(fy);
      return r;
   endfunction

   // Length of the next idle stretch: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_cycles > 0 || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 40);
   endfunction

   function automatic longint random_coord();
      coord_type c;
      c = coord_type'($urandom);
      return longint'(c);
   endfunction

   // Sizes lean small so that placed boxes overlap often, with some zero
   // sizes and a few that span most of the range.
   function automatic longint random_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return longint'($urandom_range(0, 3));
      end else if (r < 80) begin
         return longint'($urandom_range(1, 4095));
      end else if (r < 95) begin
         return longint'($urandom_range(1, 65535));
      end
      return longint'($urandom_range(0, int'(SIZE_MAX)));
   endfunction

   // Queue one box pair; values outside a field wrap to its width.
   task automatic add_pair(input longint al, input longint at, input longint aw,
                           input longint ah, input longint bl, input longint bt,
                           input longint bw, input longint bh);
      req_item_type p;
      p.a_left   = coord_type'(al);
      p.a_top    = coord_type'(at);
      p.a_width  = size_type'(aw);
      p.a_height = size_type'(ah);
      p.b_left   = coord_type'(bl);
      p.b_top    = coord_type'(bt);
      p.b_width  = size_type'(bw);
      p.b_height = size_type'(bh);
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   task automatic add_random_pair();
      longint al, at, aw, ah, bl, bt, bw, bh;
      longint base_x, base_y;
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 50) begin
         // Boxes placed so that their extents nearly always meet, which
         // drives the side selection and the corrections hard.
         aw = random_size();
         ah = random_size();
         bw = random_size();
         bh = random_size();
         al = random_coord();
         at = random_coord();
         bl = al - bw + longint'($urandom_range(0, int'(aw + bw)));
         bt = at - bh + longint'($urandom_range(0, int'(ah + bh)));
      end else if (mode < 65) begin
         // A tiny grid, so that equal depths and touching edges are common.
         base_x = random_coord();
         base_y = random_coord();
         al = base_x + longint'($urandom_range(0, 12));
         at = base_y + longint'($urandom_range(0, 12));
         bl = base_x + longint'($urandom_range(0, 12));
         bt = base_y + longint'($urandom_range(0, 12));
         aw = longint'($urandom_range(0, 8));
         ah = longint'($urandom_range(0, 8));
         bw = longint'($urandom_range(0, 8));
         bh = longint'($urandom_range(0, 8));
      end else if (mode < 80) begin
         // Edges near the ends of the range and large boxes, so that the
         // corrected corner often has to saturate.
         al = $urandom_range(0, 1) ? COORD_MIN + $urandom_range(0, 4095)
                                   : COORD_MAX - $urandom_range(0, 4095);
         at = $urandom_range(0, 1) ? COORD_MIN + $urandom_range(0, 4095)
                                   : COORD_MAX - $urandom_range(0, 4095);
         bl = $urandom_range(0, 1) ? COORD_MIN + $urandom_range(0, 4095)
                                   : COORD_MAX - $urandom_range(0, 4095);
         bt = $urandom_range(0, 1) ? COORD_MIN + $urandom_range(0, 4095)
                                   : COORD_MAX - $urandom_range(0, 4095);
         aw = $urandom_range(0, 1) ? SIZE_MAX - $urandom_range(0, 4095)
                                   : longint'($urandom_range(0, 4095));
         ah = $urandom_range(0, 1) ? SIZE_MAX - $urandom_range(0, 4095)
                                   : longint'($urandom_range(0, 4095));
         bw = $urandom_range(0, 1) ? SIZE_MAX - $urandom_range(0, 4095)
                                   : longint'($urandom_range(0, 4095));
         bh = $urandom_range(0, 1) ? SIZE_MAX - $urandom_range(0, 4095)
                                   : longint'($urandom_range(0, 4095));
      end else begin
         // Raw random bits in every field.
         al = longint'($urandom);
         at = longint'($urandom);
         aw = longint'($urandom);
         ah = longint'($urandom);
         bl = longint'($urandom);
         bt = longint'($urandom);
         bw = longint'($urandom);
         bh = longint'($urandom);
      end
      add_pair(al, at, aw, ah, bl, bt, bw, bh);
   endtask

   // Request side: offer queued pairs one at a time, hold each until it is
   // taken, and record what the block must answer for it.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         pair_held = 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_resolves.insert(expected_resolves.size(), resolve_pair(pair_on_bus));
            pair_held = 1'b0;
            send_gap = pick_gap();
         end
         if (!pair_held) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_pairs.size() > 0) begin
               pair_on_bus = pending_pairs.pop_front();
               pair_held = 1'b1;
               req_bus.a_left   <= pair_on_bus.a_left;
               req_bus.a_top    <= pair_on_bus.a_top;
               req_bus.a_width  <= pair_on_bus.a_width;
               req_bus.a_height <= pair_on_bus.a_height;
               req_bus.b_left   <= pair_on_bus.b_left;
               req_bus.b_top    <= pair_on_bus.b_top;
               req_bus.b_width  <= pair_on_bus.b_width;
               req_bus.b_height <= pair_on_bus.b_height;
            end
         end
         // One assignment per edge, so a valid that stays high for the next
         // item never drops in between.
         req_bus.valid <= pair_held;
      end
   end

   // Result side: check every result the block hands over against the oldest
   // outstanding expectation, and stall the channel at random.
   always @(posedge clock) begin : result_watch
      rsp_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_resolves.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("%0t: result with nothing outstanding: overlap %0b side %0d fix (%0d, %0d)",
                           $realtime, rsp_bus.overlap, rsp_bus.side, rsp_bus.fix_x,
                           rsp_bus.fix_y);
               end
            end else begin
               want = expected_resolves.pop_front();
               if (rsp_bus.overlap !== want.overlap || rsp_bus.side !== want.side ||
                   rsp_bus.fix_x !== want.fix_x || rsp_bus.fix_y !== want.fix_y) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected overlap %0b side %0d fix (%0d, %0d), got overlap %0b side %0d fix (%0d, %0d)",
                              $realtime, want.overlap, want.side, want.fix_x, want.fix_y,
                              rsp_bus.overlap, rsp_bus.side, rsp_bus.fix_x,
                              rsp_bus.fix_y);
                  end
               end
            end
            sink_stall = pick_gap();
         end else if (rsp_bus.ready && $urandom_range(0, 7) == 0) begin
            // Stalls also start while nothing is offered, so they land on
            // every stage of the pipeline.
            sink_stall = pick_gap();
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Cycle count for the timeout, and the occasional stretch without gaps.
   always @(posedge clock) begin
      cycle_count++;
      if (calm_cycles > 0) begin
         calm_cycles--;
      end else if ($urandom_range(0, 299) == 0) begin
         calm_cycles = $urandom_range(40, 160);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_aabb_collision_resolve_unit: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.a_left   = '0;
      req_bus.a_top    = '0;
      req_bus.a_width  = '0;
      req_bus.a_height = '0;
      req_bus.b_left   = '0;
      req_bus.b_top    = '0;
      req_bus.b_width  = '0;
      req_bus.b_height = '0;
      rsp_bus.ready    = 1'b0;

      // Degenerate and extreme pairs: everything zero, everything at the top
      // of its range (equal boxes tie on all four depths), equal boxes from
      // the bottom of the coordinate range, and boxes of no size at all.
      add_pair(0, 0, 0, 0, 0, 0, 0, 0);
      add_pair(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX,
               COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
      add_pair(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
               COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
      add_pair(COORD_MIN, COORD_MIN, 0, 0, COORD_MIN, COORD_MIN, 0, 0);

      // One clear contact on each side of A.
      add_pair(0, 0, 100, 100, -50, 90, 200, 100);
      add_pair(0, 90, 100, 100, -50, 0, 200, 100);
      add_pair(0, 0, 100, 100, 90, -50, 100, 200);
      add_pair(90, 0, 100, 100, 0, -50, 100, 200);

      // Equal depths on two axes at a corner give no side.
      add_pair(0, 0, 100, 100, 90, 90, 100, 100);

      // Edges that only touch, on either axis, are no overlap.
      add_pair(0, 0, 100, 100, 100, 0, 100, 100);
      add_pair(0, 0, 100, 100, 0, -100, 100, 100);

      // A box of zero width inside the other one is no overlap either.
      add_pair(50, 50, 0, 20, 0, 0, 100, 100);

      // A encloses B: the shallowest way out is still chosen.
      add_pair(0, 0, 1000, 1000, 400, 100, 200, 200);

      // Corrected corner beyond the coordinate range, once per direction.
      add_pair(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
               COORD_MIN, COORD_MIN + 10, SIZE_MAX, SIZE_MAX);
      add_pair(COORD_MIN, COORD_MAX - 7, SIZE_MAX, SIZE_MAX,
               COORD_MIN, COORD_MAX - 17, SIZE_MAX, 20);
      add_pair(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
               COORD_MIN + 10, COORD_MIN, SIZE_MAX, SIZE_MAX);
      add_pair(COORD_MAX - 7, COORD_MIN, SIZE_MAX, SIZE_MAX,
               COORD_MAX - 17, COORD_MIN, 20, SIZE_MAX);

      // Boxes at opposite ends of the range.
      add_pair(COORD_MIN, COORD_MIN, 256, 256, COORD_MAX - 255, COORD_MAX - 255, 255, 255);

      repeat (RANDOM_PAIRS) begin
         add_random_pair();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || pair_held || expected_resolves.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("tb_aabb_collision_resolve_unit: PASS");
      end else begin
         $display("tb_aabb_collision_resolve_unit: FAIL");
      end
      $finish;
   end

endmodule
